// ===== hw/rtl/artc_pkg.sv =====
package artc_pkg;

    // Default reply capacity in bytes and depth of the blank run counter.
    localparam int ARTC_CAPACITY    = 1024;
    localparam int ARTC_BLANK_DEPTH = 12;

    // Depth of the queue between the classifier and the matcher.
    localparam int QUEUE_DEPTH = 2;

    // Width of the captured byte count shown on the result.
    localparam int CAPTURED_W = 10;

    // Match position saturates here.
    localparam logic [3:0] POS_MAX = 4'd15;

    // Characters with a special role.
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;

    // Final result patterns. OK gives ok, the rest give error, and the two
    // extended error codes only need to match as a line prefix.
    localparam int PAT_COUNT = 7;
    localparam int PAT_MAX   = 11;
    localparam int PAT_OK    = 0;
    localparam int PAT_CME   = 2;
    localparam int PAT_CMS   = 3;

    localparam logic [3:0] PAT_LEN [PAT_COUNT] =
        '{4'd2, 4'd5, 4'd11, 4'd11, 4'd10, 4'd9, 4'd4};

    // Each string is right aligned in its vector, first character highest.
    localparam logic [8*PAT_MAX-1:0] PAT_TEXT [PAT_COUNT] =
        '{"OK", "ERROR", "+CME ERROR:", "+CMS ERROR:",
          "NO CARRIER", "NO ANSWER", "BUSY"};

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_OK      = 2'd1,
        ST_ERROR   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_TEXT  = 2'd0,
        CLS_BLANK = 2'd1,
        CLS_LF    = 2'd2,
        CLS_BAD   = 2'd3
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       transport_fault;
    } artc_in_t;

    typedef struct packed {
        status_t               status;
        logic                  overflow;
        logic                  finished;
        logic [CAPTURED_W-1:0] captured;
    } artc_out_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [7:0]  data_byte;
        byte_class_t byte_class;
        logic        start_req;
        logic        transport_fault;
    } artc_entry_t;

    // Character at position pos of pattern idx; the caller keeps pos below
    // the pattern length.
    function automatic logic [7:0] pat_char(input int idx, input logic [3:0] pos);
        logic [3:0] sel;
        sel = PAT_LEN[idx] - 4'd1 - pos;
        return PAT_TEXT[idx][{sel, 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/at_reply_terminal_classifier_unit.sv =====
// An accepted item is queued; when popped, its result is written to the output register.
// Throughput: one item per cycle unless stalled; all seven patterns update combinationally.
// A two-entry queue between classifier and matcher and an output register decouple stalls.
// Reset (rst_n low, asynchronous) clears status, overflow, count and line match state.
// No clearing pass is needed; the block accepts items directly after reset.
module at_reply_terminal_classifier_unit
    import artc_pkg::*;
#(
    parameter int CAPACITY    = ARTC_CAPACITY,
    parameter int BLANK_DEPTH = ARTC_BLANK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  artc_in_t  byte_item,
    output logic      result_valid,
    input  logic      result_stall,
    output artc_out_t result_item
);

    artc_entry_t front_entry;
    artc_entry_t q_entry;
    logic        q_valid;
    logic        q_pop;

    // Byte classification.
    artc_front u_front (
        .item  (byte_item),
        .entry (front_entry)
    );

    // Queue between the classifier and the matcher.
    artc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (byte_valid),
        .full       (byte_stall),
        .push_entry (front_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    // Pattern matcher and reply status.
    artc_back #(
        .CAPACITY    (CAPACITY),
        .BLANK_DEPTH (BLANK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== hw/rtl/artc_front.sv =====
module artc_front
    import artc_pkg::*;
(
    input  artc_in_t    item,
    output artc_entry_t entry
);

    byte_class_t byte_class;

    // Sort the byte into line end, blank, printable text or illegal.
    always_comb
    begin
        priority if (item.data_byte == CHAR_LF)
        begin
            byte_class = CLS_LF;
        end
        else if (item.data_byte == CHAR_SPACE || item.data_byte == CHAR_TAB ||
                 item.data_byte == CHAR_CR)
        begin
            byte_class = CLS_BLANK;
        end
        else if (item.data_byte > CHAR_SPACE && item.data_byte <= CHAR_TILDE)
        begin
            byte_class = CLS_TEXT;
        end
        else
        begin
            byte_class = CLS_BAD;
        end
    end

    // Pack the classified item for the queue.
    always_comb
    begin
        entry.data_byte       = item.data_byte;
        entry.byte_class      = byte_class;
        entry.start_req       = item.start_req;
        entry.transport_fault = item.transport_fault;
    end

endmodule

// ===== hw/rtl/artc_queue.sv =====
module artc_queue
    import artc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        full,
    input  artc_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop,
    output artc_entry_t pop_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    artc_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push      = push_valid && !full;
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/artc_back.sv =====
module artc_back
    import artc_pkg::*;
#(
    parameter int CAPACITY    = ARTC_CAPACITY,
    parameter int BLANK_DEPTH = ARTC_BLANK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  artc_entry_t q_entry,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output artc_out_t   result_item
);

    localparam int CNT_W  = $clog2(CAPACITY);
    localparam int PEND_W = $clog2(BLANK_DEPTH + 1);
    localparam int SUM_W  = PEND_W + 2;

    typedef struct packed {
        logic [PAT_COUNT-1:0] mask;
        logic [3:0]           pos;
        logic [1:0]           hits;
    } line_t;

    localparam line_t LINE_CLEAR = '{mask: '1, pos: '0, hits: '0};

    status_t           status_reg;
    status_t           status_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    line_t             line_reg;
    line_t             line_next;
    logic              content_reg;
    logic              content_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [7:0]        blank_reg;
    logic [7:0]        blank_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    artc_out_t         out_reg;
    artc_out_t         out_next;

    // One character step of every live pattern.
    function automatic line_t feed(input line_t s, input logic [7:0] c);
        line_t r;
        r = s;
        for (int i = 0; i < PAT_COUNT; i++)
        begin
            if (s.mask[i])
            begin
                if (s.pos < PAT_LEN[i] && pat_char(i, s.pos) == c)
                begin
                    if (s.pos == PAT_LEN[i] - 4'd1)
                    begin
                        if (i == PAT_CME)
                        begin
                            r.hits[0] = 1'b1;
                        end
                        if (i == PAT_CMS)
                        begin
                            r.hits[1] = 1'b1;
                        end
                    end
                end
                else
                begin
                    r.mask[i] = 1'b0;
                end
            end
        end
        if (s.pos != POS_MAX)
        begin
            r.pos = s.pos + 4'd1;
        end
        return r;
    endfunction

    // Outcome of a completed line.
    function automatic status_t line_result(input line_t m, input logic content);
        status_t r;
        r = ST_WAIT;
        if (content)
        begin
            if (m.mask[PAT_OK] && m.pos == PAT_LEN[PAT_OK])
            begin
                r = ST_OK;
            end
            else if (m.hits != 2'b00)
            begin
                r = ST_ERROR;
            end
            else
            begin
                for (int i = 1; i < PAT_COUNT; i++)
                begin
                    if (i != PAT_CME && i != PAT_CMS && m.mask[i] &&
                        m.pos == PAT_LEN[i])
                    begin
                        r = ST_ERROR;
                    end
                end
            end
        end
        return r;
    endfunction

    assign q_pop        = q_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    // Reply state update for the item at the head of the queue.
    // No pattern has two blanks in a row, so a held run of two or more
    // blanks kills every candidate and only advances the position.
    always_comb
    begin
        status_t                 cur_status;
        logic                    cur_ovf;
        logic [CNT_W-1:0]        cur_cnt;
        line_t                   cur_line;
        logic                    cur_content;
        logic [PEND_W-1:0]       cur_pend;
        line_t                   flushed;
        logic [SUM_W-1:0]        pos_sum;
        status_t                 found;
        logic [CNT_W+CAPTURED_W-1:0] cnt_wide;

        if (q_entry.start_req)
        begin
            cur_status  = ST_WAIT;
            cur_ovf     = 1'b0;
            cur_cnt     = '0;
            cur_line    = LINE_CLEAR;
            cur_content = 1'b0;
            cur_pend    = '0;
        end
        else
        begin
            cur_status  = status_reg;
            cur_ovf     = ovf_reg;
            cur_cnt     = cnt_reg;
            cur_line    = line_reg;
            cur_content = content_reg;
            cur_pend    = pend_reg;
        end

        status_next  = cur_status;
        ovf_next     = cur_ovf;
        cnt_next     = cur_cnt;
        line_next    = cur_line;
        content_next = cur_content;
        pend_next    = cur_pend;
        blank_next   = blank_reg;

        flushed = cur_line;
        pos_sum = SUM_W'(cur_line.pos) + SUM_W'(cur_pend);
        if (cur_pend != '0)
        begin
            flushed = feed(cur_line, blank_reg);
        end
        if (cur_pend > PEND_W'(1))
        begin
            flushed.mask = '0;
            flushed.pos  = (pos_sum > SUM_W'(POS_MAX)) ? POS_MAX : pos_sum[3:0];
        end
        found = line_result(cur_line, cur_content);

        if (q_entry.transport_fault)
        begin
            status_next = ST_INVALID;
        end
        else if (cur_ovf || cur_cnt == CNT_W'(CAPACITY - 1))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            cnt_next = cur_cnt + CNT_W'(1);
            unique case (q_entry.byte_class)
                CLS_BAD:
                begin
                    status_next = ST_INVALID;
                end
                CLS_LF:
                begin
                    if (cur_status != ST_INVALID)
                    begin
                        if (found != ST_WAIT)
                        begin
                            status_next = (cur_status != ST_WAIT) ? ST_INVALID : found;
                        end
                        line_next    = LINE_CLEAR;
                        content_next = 1'b0;
                        pend_next    = '0;
                    end
                end
                CLS_BLANK:
                begin
                    if (cur_status != ST_INVALID && cur_content &&
                        cur_pend < PEND_W'(BLANK_DEPTH))
                    begin
                        if (cur_pend == '0)
                        begin
                            blank_next = q_entry.data_byte;
                        end
                        pend_next = cur_pend + PEND_W'(1);
                    end
                end
                CLS_TEXT:
                begin
                    if (cur_status != ST_INVALID)
                    begin
                        line_next    = feed(flushed, q_entry.data_byte);
                        content_next = 1'b1;
                        pend_next    = '0;
                    end
                end
                default:
                begin
                    status_next = cur_status;
                end
            endcase
        end

        cnt_wide          = {{CAPTURED_W{1'b0}}, cnt_next};
        out_next.status   = status_next;
        out_next.overflow = ovf_next;
        out_next.finished = ovf_next || (status_next != ST_WAIT);
        out_next.captured = cnt_wide[CAPTURED_W-1:0];
    end

    // The output register holds a result while the consumer stalls it.
    always_comb
    begin
        out_valid_next = q_pop || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= ST_WAIT;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            line_reg      <= LINE_CLEAR;
            content_reg   <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                status_reg  <= status_next;
                ovf_reg     <= ovf_next;
                cnt_reg     <= cnt_next;
                line_reg    <= line_next;
                content_reg <= content_next;
                pend_reg    <= pend_next;
            end
        end
    end

    // Held blank and result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            blank_reg <= blank_next;
            out_reg   <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && !(q_pop && q_entry.start_req) |=> ovf_reg)
        else $error("overflow cleared without a start request");

    a_invalid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_INVALID) && !(q_pop && q_entry.start_req)
        |=> (status_reg == ST_INVALID))
        else $error("invalid status left without a start request");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY - 1))
        else $error("byte count passed capacity");

    a_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.finished ==
                           (out_reg.overflow || out_reg.status != ST_WAIT)))
        else $error("finished flag disagrees with status and overflow");
`endif

endmodule

// ===== test/at_reply_result_checker.sv =====
module at_reply_result_checker
    import artc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    input  logic      byte_stall,
    input  artc_in_t  byte_item,
    input  logic      result_valid,
    input  logic      result_stall,
    input  artc_out_t result_item,
    output int        mismatches,
    output int        awaited,
    output int        results_checked,
    output int        finished_seen,
    output int        overflow_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REPLY_CAPACITY = ARTC_CAPACITY;
    localparam int unsigned BLANK_SLOTS    = ARTC_BLANK_DEPTH;
    localparam int unsigned CODE_COUNT     = 7;
    localparam int unsigned POS_LIMIT      = 15;

    // Indexes into the table of final result codes.
    localparam int unsigned CODE_OK  = 0;
    localparam int unsigned CODE_CME = 2;
    localparam int unsigned CODE_CMS = 3;

    // The first code means ok, all others mean error. The two extended error
    // codes only have to match the start of a line.
    string final_codes [CODE_COUNT] = '{"OK", "ERROR", "+CME ERROR:", "+CMS ERROR:",
                                        "NO CARRIER", "NO ANSWER", "BUSY"};

    // Running view of the reply as the block should see it.
    status_t      running_status;
    bit           overflowed;
    int unsigned  kept_bytes;
    int unsigned  match_pos;
    bit [6:0]     candidates;
    bit [1:0]     prefix_hits;
    bit           line_started;
    logic [7:0]   held_blanks [BLANK_SLOTS];
    int unsigned  held_count;

    artc_out_t    awaited_replies [$];

    function automatic void clear_line();
        match_pos    = 0;
        candidates   = '1;
        prefix_hits  = '0;
        line_started = 1'b0;
        held_count   = 0;
    endfunction

    function automatic void clear_reply();
        running_status = ST_WAIT;
        overflowed     = 1'b0;
        kept_bytes     = 0;
        clear_line();
    endfunction

    // Advance every code still in the running by one character of the line.
    function automatic void match_char(input logic [7:0] c);
        int unsigned code_len;
        for (int unsigned i = 0; i < CODE_COUNT; i++)
        begin
            code_len = final_codes[i].len();
            if (candidates[i])
            begin
                if (match_pos < code_len && 8'(final_codes[i][match_pos]) == c)
                begin
                    if ((i == CODE_CME || i == CODE_CMS) && match_pos + 1 == code_len)
                        prefix_hits[i - CODE_CME] = 1'b1;
                end
                else
                begin
                    candidates[i] = 1'b0;
                end
            end
        end
        if (match_pos < POS_LIMIT)
            match_pos++;
    endfunction

    // Outcome of a line that has just been closed by LF.
    function automatic status_t line_outcome();
        if (!line_started)
            return ST_WAIT;
        if (candidates[CODE_OK] && match_pos == final_codes[CODE_OK].len())
            return ST_OK;
        if (prefix_hits != '0)
            return ST_ERROR;
        for (int unsigned i = 1; i < CODE_COUNT; i++)
        begin
            if (i != CODE_CME && i != CODE_CMS && candidates[i]
                && match_pos == final_codes[i].len())
                return ST_ERROR;
        end
        return ST_WAIT;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        bit      printable;
        status_t found;
        printable = (c >= CHAR_SPACE && c <= CHAR_TILDE) || c == CHAR_TAB
                    || c == CHAR_LF || c == CHAR_CR;
        if (!printable)
        begin
            running_status = ST_INVALID;
        end
        else if (running_status != ST_INVALID)
        begin
            if (c == CHAR_LF)
            begin
                found = line_outcome();
                if (found != ST_WAIT)
                    running_status = (running_status != ST_WAIT) ? ST_INVALID : found;
                clear_line();
            end
            else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR)
            begin
                // Blanks only count once more text follows on the same line.
                if (line_started && held_count < BLANK_SLOTS)
                begin
                    held_blanks[held_count] = c;
                    held_count++;
                end
            end
            else
            begin
                for (int unsigned k = 0; k < held_count; k++)
                    match_char(held_blanks[k]);
                held_count = 0;
                match_char(c);
                line_started = 1'b1;
            end
        end
    endfunction

    // Reply status after one more byte.
    function automatic artc_out_t reply_after_byte(input artc_in_t item);
        artc_out_t r;
        if (item.start_req)
            clear_reply();
        if (item.transport_fault)
        begin
            running_status = ST_INVALID;
        end
        else if (overflowed || kept_bytes >= REPLY_CAPACITY - 1)
        begin
            overflowed = 1'b1;
        end
        else
        begin
            kept_bytes++;
            take_char(item.data_byte);
        end
        r.status   = running_status;
        r.overflow = overflowed;
        r.finished = overflowed || running_status != ST_WAIT;
        r.captured = kept_bytes[CAPTURED_W-1:0];
        return r;
    endfunction

    function automatic void flag_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Results are checked before the byte of the same edge is predicted, so
    // a stray result can never pair with an item that just went in.
    always @(posedge clk or negedge rst_n)
    begin
        artc_out_t want;
        if (!rst_n)
        begin
            clear_reply();
            awaited_replies.delete();
            mismatches      = 0;
            results_checked = 0;
            finished_seen   = 0;
            overflow_seen   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (result_item.finished)
                    finished_seen++;
                if (result_item.overflow)
                    overflow_seen++;
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: status %0d ovf %0d fin %0d captured %0d",
                             $time, result_item.status, result_item.overflow,
                             result_item.finished, result_item.captured);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    flag_field("status", want.status, result_item.status);
                    flag_field("overflow", want.overflow, result_item.overflow);
                    flag_field("finished", want.finished, result_item.finished);
                    flag_field("captured", want.captured, result_item.captured);
                end
            end
            if (byte_valid && !byte_stall)
                awaited_replies.push_back(reply_after_byte(byte_item));
        end
        awaited = awaited_replies.size();
    end

endmodule

// ===== test/at_reply_terminal_classifier_unit_test.sv =====
module at_reply_terminal_classifier_unit_test
    import artc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD        = 2;
    localparam int TOTAL_ITEMS        = 1800;
    localparam int OVERFLOW_REPLY_LEN = 1040;
    localparam int LONG_HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES       = 10;
    localparam int RUN_LIMIT_NS       = 2_000_000;
    localparam int MAX_IDLE           = 19;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    artc_in_t  byte_item;
    logic      result_valid;
    logic      result_stall;
    artc_out_t result_item;

    int mismatches;
    int awaited;
    int results_checked;
    int finished_seen;
    int overflow_seen;

    int         items_sent;
    bit         sender_idles;
    bit         receiver_idles;
    bit         hold_off_req;
    logic [7:0] reply_bytes [$];

    // Lines that must not end a reply, near misses among them.
    string info_lines [18] = '{"AT", "ATD123;", "+CSQ: 23,99", "RING", "CONNECT 9600",
                               "+CREG: 0,1", "> ", "OKAY", "O K", "ERRO", "BUSY!",
                               "+CME ERROR", "+CMS ERR", "NO CARRIERS", "ok", "NO ANSWE",
                               "ERROR 1", "OK1"};
    string final_lines [8] = '{"OK", "ERROR", "+CME ERROR: 10", "+CMS ERROR: 500",
                               "+CME ERROR:", "NO CARRIER", "NO ANSWER", "BUSY"};

    at_reply_terminal_classifier_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    at_reply_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .byte_item       (byte_item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_item     (result_item),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .finished_seen   (finished_seen),
        .overflow_seen   (overflow_seen)
    );

    always #HALF_PERIOD clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            default: return CHAR_CR;
        endcase
    endfunction

    // Head and tail joined by a run of blanks, to exercise the blank store.
    function automatic string spaced(input string head, input int unsigned run,
                                     input string tail);
        string s;
        s = head;
        repeat (run) s = $sformatf("%s%c", s, pick_blank());
        return {s, tail};
    endfunction

    // One line with optional blanks around it and the odd bad byte inside.
    function automatic void add_line(input string body);
        repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0)
            reply_bytes.push_back(pick_blank());
        for (int i = 0; i < body.len(); i++)
        begin
            if ($urandom_range(0, 199) == 0)
                reply_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                                          : 8'($urandom_range(128, 255)));
            reply_bytes.push_back(8'(body[i]));
        end
        repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0)
            reply_bytes.push_back(pick_blank());
        reply_bytes.push_back(CHAR_LF);
    endfunction

    // A reply: echo and info lines, usually a final line, sometimes a second
    // final line, a blank line or a partial line without LF.
    function automatic void build_reply();
        int unsigned pick;
        reply_bytes.delete();
        repeat ($urandom_range(0, 2))
            add_line(info_lines[$urandom_range(0, $size(info_lines) - 1)]);
        if ($urandom_range(0, 5) == 0)
            add_line("");
        pick = $urandom_range(0, 19);
        if (pick == 0)
            add_line(spaced("NO", $urandom_range(1, 16), "CARRIER"));
        else if (pick == 1)
            add_line(spaced("+CMS", $urandom_range(1, 14), "ERROR: 7"));
        else if (pick == 2)
            add_line(spaced("O", $urandom_range(11, 14), "K"));
        else if (pick < 17)
            add_line(final_lines[$urandom_range(0, $size(final_lines) - 1)]);
        if ($urandom_range(0, 7) == 0)
            add_line(final_lines[$urandom_range(0, $size(final_lines) - 1)]);
        if ($urandom_range(0, 7) == 0)
        begin
            add_line(final_lines[$urandom_range(0, $size(final_lines) - 1)]);
            void'(reply_bytes.pop_back());
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic start, input logic fault);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_item  <= '{data_byte: data, start_req: start, transport_fault: fault};
        byte_valid <= 1'b1;
        do @(posedge clk); while (byte_stall);
        items_sent++;
    endtask

    task automatic send_reply(input bit start_first, input int unsigned fault_odds);
        for (int i = 0; i < reply_bytes.size(); i++)
            send_item(reply_bytes[i], start_first && i == 0,
                      fault_odds != 0 && $urandom_range(1, fault_odds) == 1);
    endtask

    task automatic send_text(input string text, input bit start_first);
        reply_bytes.delete();
        for (int i = 0; i < text.len(); i++)
            reply_bytes.push_back(8'(text[i]));
        send_reply(start_first, 0);
    endtask

    // Result side: a random hold before each item, quiet stretches, and one
    // long hold when asked for.
    initial
    begin
        int unsigned hold;
        int unsigned taken;
        result_stall   = 1'b0;
        receiver_idles = 1'b1;
        taken          = 0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            else
            begin
                hold = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            end
            repeat (hold)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            taken++;
            if (taken % 40 == 0)
                receiver_idles = ($urandom_range(0, 2) != 0);
        end
    end

    // Byte side: reset, directed cases, then random replies and noise.
    initial
    begin
        bit long_reply_done;
        rst_n           = 1'b0;
        byte_valid      = 1'b0;
        byte_item       = '0;
        items_sent      = 0;
        sender_idles    = 1'b1;
        hold_off_req    = 1'b0;
        long_reply_done = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Trimmed OK, then a second final line that spoils it.
        send_text("\tOK\r\n", 1'b1);
        send_text("ERROR\n", 1'b0);
        // A blank line alone finishes nothing; BUSY is an error.
        send_text(" \n", 1'b1);
        send_text("BUSY\n", 1'b1);
        // Bytes outside the printable range.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h7f, 1'b0, 1'b0);
        // Transport fault together with a start.
        send_item(8'ha5, 1'b1, 1'b1);
        // A partial line never finishes the reply.
        send_text("OK", 1'b1);

        // Back-to-back bytes while the result side holds off.
        hold_off_req = 1'b1;
        sender_idles = 1'b0;
        repeat (4)
        begin
            build_reply();
            send_reply(1'b1, 0);
        end

        while (items_sent < TOTAL_ITEMS)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            if (!long_reply_done && items_sent > 400)
            begin
                // Run past capacity, then fault the truncated reply.
                reply_bytes.delete();
                while (reply_bytes.size() < OVERFLOW_REPLY_LEN)
                    add_line(info_lines[$urandom_range(0, $size(info_lines) - 1)]);
                add_line("OK");
                send_reply(1'b1, 0);
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                long_reply_done = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                              $urandom_range(0, 7) == 0);
            end
            else
            begin
                build_reply();
                send_reply(1'b1, 200);
            end
        end

        @(negedge clk);
        byte_valid <= 1'b0;
        while (awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: directed cases, random replies with faults and bad bytes,",
                 items_sent);
        $display("noise and one reply past capacity; %0d results checked,", results_checked);
        $display("%0d finished, %0d overflowed.", finished_seen, overflow_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
